### design/lfd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the length-prefixed frame deframer.
// Used by every module in the design folder; depends on nothing else.
package lfd_pkg;

    localparam logic [7:0] DEFAULT_START_BYTE = 8'h68;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2
    } phase_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       discard;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_first;
        logic       frame_last;
    } out_item_t;

    // Parser to output stage: one decision per fired item
    typedef struct packed {
        logic      emit;
        out_item_t item;
    } parse_result_t;

endpackage

### design/lfd_in_stage.sv
`timescale 1ns / 1ps
// Input register stage of the deframer: holds one accepted byte item.
// Depends on lfd_pkg.
module lfd_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  lfd_pkg::in_item_t byte_item,
    input  logic              fire,
    output logic              held_valid,
    output lfd_pkg::in_item_t held_item
);

    logic              valid_reg;
    logic              valid_next;
    lfd_pkg::in_item_t item_reg;
    logic              load;

    assign byte_ready = !valid_reg || fire;
    assign load       = byte_valid && byte_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (fire)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= byte_item;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

### design/lfd_parser.sv
`timescale 1ns / 1ps
// Frame parser: phase register, body down-counter and start byte register.
// Depends on lfd_pkg.
module lfd_parser (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [7:0]             cfg_data,
    input  logic                   held_valid,
    input  lfd_pkg::in_item_t      held_item,
    input  logic                   out_can_take,
    output logic                   fire,
    output lfd_pkg::parse_result_t result
);

    lfd_pkg::phase_t phase_reg;
    lfd_pkg::phase_t phase_next;
    logic [7:0]      remain_reg;
    logic [7:0]      remain_next;
    logic [7:0]      remain_dec;
    logic [7:0]      start_reg;

    assign fire       = held_valid && out_can_take;
    assign remain_dec = (remain_reg != 8'd0) ? remain_reg - 8'd1 : 8'd0;

    // Next state
    always_comb
    begin
        phase_next  = phase_reg;
        remain_next = remain_reg;
        if (held_item.discard)
        begin
            phase_next  = lfd_pkg::PH_HUNT;
            remain_next = 8'd0;
        end
        else
        begin
            unique case (phase_reg)
                lfd_pkg::PH_LEN:
                begin
                    phase_next  = (held_item.data_byte == 8'd0) ? lfd_pkg::PH_HUNT
                                                                 : lfd_pkg::PH_BODY;
                    remain_next = held_item.data_byte;
                end
                lfd_pkg::PH_BODY:
                begin
                    remain_next = remain_dec;
                    if (remain_dec == 8'd0)
                        phase_next = lfd_pkg::PH_HUNT;
                end
                default:
                begin
                    if (held_item.data_byte == start_reg)
                    begin
                        phase_next  = lfd_pkg::PH_LEN;
                        remain_next = 8'd0;
                    end
                    else
                        phase_next = lfd_pkg::PH_HUNT;
                end
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        result.item.frame_byte  = held_item.data_byte;
        result.item.frame_first = 1'b0;
        result.item.frame_last  = 1'b0;
        result.emit             = 1'b0;
        if (!held_item.discard)
        begin
            unique case (phase_reg)
                lfd_pkg::PH_LEN:
                begin
                    result.emit            = 1'b1;
                    result.item.frame_last = (held_item.data_byte == 8'd0);
                end
                lfd_pkg::PH_BODY:
                begin
                    result.emit            = 1'b1;
                    result.item.frame_last = (remain_dec == 8'd0);
                end
                default:
                begin
                    result.emit             = (held_item.data_byte == start_reg);
                    result.item.frame_first = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= lfd_pkg::PH_HUNT;
            remain_reg <= 8'd0;
        end
        else if (fire)
        begin
            phase_reg  <= phase_next;
            remain_reg <= remain_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            start_reg <= lfd_pkg::DEFAULT_START_BYTE;
        else if (cfg_we)
            start_reg <= cfg_data;
    end

endmodule

### design/lfd_out_stage.sv
`timescale 1ns / 1ps
// Result register of the deframer: holds one frame item until taken.
// Depends on lfd_pkg.
module lfd_out_stage (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   fire,
    input  lfd_pkg::parse_result_t result,
    output logic                   can_take,
    output logic                   frame_valid,
    input  logic                   frame_ready,
    output lfd_pkg::out_item_t     frame_item
);

    logic               valid_reg;
    logic               valid_next;
    lfd_pkg::out_item_t item_reg;
    logic               load;

    assign can_take = !valid_reg || frame_ready;
    assign load     = fire && result.emit;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (frame_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            item_reg <= result.item;
    end

    assign frame_valid = valid_reg;
    assign frame_item  = item_reg;

endmodule

### design/length_prefixed_frame_deframer.sv
`timescale 1ns / 1ps
// Top level of the length-prefixed frame deframer.
// Depends on lfd_pkg, lfd_in_stage, lfd_parser and lfd_out_stage.
//
// Takes one received byte per item and passes on the bytes of each frame:
// while hunting, bytes are dropped until one equals the start byte register
// (0x68 after reset, written through cfg_we/cfg_data); the next byte is the
// body length (0 to 255), and that many body bytes follow. Start, length and
// body bytes are forwarded as they arrive, the start byte marked frame_first
// and the final byte marked frame_last; a zero length ends the frame at the
// length byte. An item with discard set drops any partial frame, returns to
// hunting and yields no output. Each item passes an input register, the
// combinational parsing logic and a result register, and one item is taken
// every cycle while the output side keeps up; a held result stalls the parser
// only when the result register cannot be refilled.
module length_prefixed_frame_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  lfd_pkg::in_item_t  byte_item,
    output logic               frame_valid,
    input  logic               frame_ready,
    output lfd_pkg::out_item_t frame_item,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data
);

    logic                   held_valid;
    lfd_pkg::in_item_t      held_item;
    logic                   fire;
    logic                   out_can_take;
    lfd_pkg::parse_result_t result;

    // Hold the accepted byte until the parser consumes it
    lfd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .fire       (fire),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Advance the frame phase and decide whether the byte is forwarded
    lfd_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .held_valid   (held_valid),
        .held_item    (held_item),
        .out_can_take (out_can_take),
        .fire         (fire),
        .result       (result)
    );

    // Hold the forwarded item until the downstream side takes it
    lfd_out_stage u_out_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .result      (result),
        .can_take    (out_can_take),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_item  (frame_item)
    );

endmodule

### test/lfd_frame_checker.sv
`timescale 1ns / 1ps
// Checker for the length-prefixed frame deframer: watches both channels and the start byte
// register port, predicts each frame byte and compares what the block hands out.
// Depends on lfd_pkg.
module lfd_frame_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic               byte_ready,
    input  lfd_pkg::in_item_t  byte_item,
    input  logic               frame_valid,
    input  logic               frame_ready,
    input  lfd_pkg::out_item_t frame_item,
    input  logic               cfg_we,
    input  logic [7:0]         cfg_data,
    output int                 fail_count,
    output int                 frames_pending
);

    lfd_pkg::phase_t    parse_phase;
    logic [7:0]         body_left;
    logic [7:0]         start_value;
    lfd_pkg::out_item_t frame_bytes_due[$];

    // Advance the parser by one byte; return 1 when the byte belongs to a frame.
    function automatic bit deframe_byte(input lfd_pkg::in_item_t rx,
                                        output lfd_pkg::out_item_t res);
        res = '0;
        res.frame_byte = rx.data_byte;
        if (rx.discard)
        begin
            parse_phase = lfd_pkg::PH_HUNT;
            body_left = 8'd0;
            return 1'b0;
        end
        case (parse_phase)
            lfd_pkg::PH_LEN:
            begin
                if (rx.data_byte == 8'd0)
                begin
                    parse_phase = lfd_pkg::PH_HUNT;
                    body_left = 8'd0;
                    res.frame_last = 1'b1;
                end
                else
                begin
                    parse_phase = lfd_pkg::PH_BODY;
                    body_left = rx.data_byte;
                end
                return 1'b1;
            end
            lfd_pkg::PH_BODY:
            begin
                if (body_left != 8'd0)
                    body_left = body_left - 8'd1;
                if (body_left == 8'd0)
                begin
                    parse_phase = lfd_pkg::PH_HUNT;
                    res.frame_last = 1'b1;
                end
                return 1'b1;
            end
            default:
            begin
                if (rx.data_byte == start_value)
                begin
                    parse_phase = lfd_pkg::PH_LEN;
                    body_left = 8'd0;
                    res.frame_first = 1'b1;
                    return 1'b1;
                end
                parse_phase = lfd_pkg::PH_HUNT;
                return 1'b0;
            end
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lfd_pkg::out_item_t due;
        lfd_pkg::out_item_t predicted;
        if (!rst_n)
        begin
            parse_phase = lfd_pkg::PH_HUNT;
            body_left = 8'd0;
            start_value = lfd_pkg::DEFAULT_START_BYTE;
            frame_bytes_due.delete();
            fail_count = 0;
            frames_pending = 0;
        end
        else
        begin
            if (cfg_we)
                start_value = cfg_data;
            // Retire the output first: it always stems from an earlier input.
            if (frame_valid && frame_ready)
            begin
                if (frame_bytes_due.size() == 0)
                begin
                    $error("frame_item: unexpected byte %02h first=%0b last=%0b",
                           frame_item.frame_byte, frame_item.frame_first,
                           frame_item.frame_last);
                    fail_count++;
                end
                else
                begin
                    due = frame_bytes_due.pop_front();
                    if (frame_item.frame_byte !== due.frame_byte)
                    begin
                        $error("frame_byte: expected %02h, actual %02h",
                               due.frame_byte, frame_item.frame_byte);
                        fail_count++;
                    end
                    if (frame_item.frame_first !== due.frame_first)
                    begin
                        $error("frame_first: expected %0b, actual %0b",
                               due.frame_first, frame_item.frame_first);
                        fail_count++;
                    end
                    if (frame_item.frame_last !== due.frame_last)
                    begin
                        $error("frame_last: expected %0b, actual %0b",
                               due.frame_last, frame_item.frame_last);
                        fail_count++;
                    end
                end
            end
            if (byte_valid && byte_ready)
            begin
                if (deframe_byte(byte_item, predicted))
                    frame_bytes_due.push_back(predicted);
            end
            frames_pending = frame_bytes_due.size();
        end
    end

endmodule

### test/length_prefixed_frame_deframer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the length-prefixed frame deframer: drives byte items, random
// output stalls and start byte writes, and gives the verdict.
// Depends on lfd_pkg, length_prefixed_frame_deframer and lfd_frame_checker.
module length_prefixed_frame_deframer_tb;

    // Cycles with no item moving on either side before the run is declared hung.
    // The longest legal quiet stretch is one long stall or a drain.
    localparam int HANG_LIMIT = 1000;
    // Cycles to let a dropped or discarded byte clear the pipeline.
    localparam int SETTLE_CYCLES = 6;

    logic               clk;
    logic               rst_n;
    logic               byte_valid;
    logic               byte_ready;
    lfd_pkg::in_item_t  byte_item;
    logic               frame_valid;
    logic               frame_ready;
    lfd_pkg::out_item_t frame_item;
    logic               cfg_we;
    logic [7:0]         cfg_data;

    int         fail_count;
    int         frames_pending;
    int         quiet_cycles;
    int         sink_hold;
    int         bytes_sent;
    bit         calm;          // 1: no gaps on either side
    logic [7:0] start_value;   // start byte currently programmed

    length_prefixed_frame_deframer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_item   (byte_item),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame_item  (frame_item),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data)
    );

    lfd_frame_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_item      (byte_item),
        .frame_valid    (frame_valid),
        .frame_ready    (frame_ready),
        .frame_item     (frame_item),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .frames_pending (frames_pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Gap length shared by both sides: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Body length: mostly short frames, some medium, rarely the full 255.
    function automatic logic [7:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2)
            return 8'd255;
        if (r < 8)
            return 8'($urandom_range(13, 64));
        return 8'($urandom_range(0, 12));
    endfunction

    // Noise byte for hunting; steer clear of the start byte so the next frame lines up.
    function automatic logic [7:0] pick_noise();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == start_value)
            b = b ^ 8'h01;
        return b;
    endfunction

    // Receiver: drop ready for random stretches; change only at the falling edge.
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            frame_ready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else
        begin
            frame_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                sink_hold = pick_gap();
        end
    end

    // Watchdog: count cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((byte_valid && byte_ready) || (frame_valid && frame_ready))
                quiet_cycles = 0;
            else
                quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Present one byte item; called and returning at a falling edge.
    // Valid is assigned once per step, so back-to-back items keep it high.
    task automatic push_byte(input logic [7:0] b, input logic drop);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item <= '{data_byte: b, discard: drop};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        @(negedge clk);
        if (!drop)
            bytes_sent++;
    endtask

    // Hold the sender until every predicted frame byte has come out, then let
    // dropped bytes still in flight clear.
    task automatic drain_frames();
        byte_valid <= 1'b0;
        while (frames_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_start_byte(input logic [7:0] value);
        drain_frames();
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        start_value = value;
    endtask

    // Send start, length and body_cnt body bytes of a frame of length len.
    task automatic send_frame(input logic [7:0] len, input int body_cnt);
        push_byte(start_value, 1'b0);
        push_byte(len, 1'b0);
        for (int i = 0; i < body_cnt; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // Random traffic: mostly well-formed frames, the rest noise, lone discards, broken frames and pauses.
    task automatic stream_traffic(input int target);
        int         r;
        logic [7:0] len;
        bytes_sent = 0;
        while (bytes_sent < target)
        begin
            r = $urandom_range(0, 99);
            len = pick_length();
            if (r < 65)
            begin
                send_frame(len, len);
            end
            else if (r < 75)
            begin
                repeat ($urandom_range(1, 4)) push_byte(pick_noise(), 1'b0);
            end
            else if (r < 85)
            begin
                // Cut the frame short with a discard.
                send_frame(len, (len == 0) ? 0 : $urandom_range(0, len - 1));
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (r < 90)
            begin
                // Cut short without a discard: the next frame lands inside this one.
                send_frame(len, (len == 0) ? 0 : $urandom_range(0, len - 1));
            end
            else if (r < 95)
            begin
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else if (r < 98)
            begin
                push_byte(start_value, 1'b0);
                push_byte(8'($urandom_range(0, 255)), 1'b1);
            end
            else
            begin
                // Pause the sender until the output side has caught up.
                drain_frames();
            end
        end
    endtask

    initial
    begin
        logic [7:0] settings [5];
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_item = '0;
        frame_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 8'h00;
        quiet_cycles = 0;
        sink_hold = 0;
        bytes_sent = 0;
        calm = 1'b0;
        start_value = lfd_pkg::DEFAULT_START_BYTE;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part, default start byte from reset.
        push_byte(8'h00, 1'b0);               // dropped while hunting
        push_byte(8'hFF, 1'b0);
        send_frame(8'h00, 0);                 // zero length ends at the length byte
        send_frame(8'h01, 0);
        push_byte(8'hFF, 1'b0);
        send_frame(8'h02, 0);                 // start byte value inside a frame
        push_byte(start_value, 1'b0);
        push_byte(start_value, 1'b0);
        send_frame(8'h05, 0);                 // discard in the body
        push_byte(8'h11, 1'b0);
        push_byte(8'hFF, 1'b1);
        push_byte(start_value, 1'b1);         // discard while hunting, byte ignored
        push_byte(start_value, 1'b0);         // discard while the length is due
        push_byte(8'h00, 1'b1);
        send_frame(8'h03, 0);                 // discard right after the last byte
        push_byte(8'hA5, 1'b0);
        push_byte(8'h5A, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h68, 1'b1);

        // Random part over several start bytes, extremes included; the third
        // setting runs without gaps on either side.
        settings[0] = lfd_pkg::DEFAULT_START_BYTE;
        settings[1] = 8'h00;
        settings[2] = 8'hFF;
        settings[3] = 8'($urandom_range(1, 254));
        settings[4] = lfd_pkg::DEFAULT_START_BYTE;
        for (int p = 0; p < 5; p++)
        begin
            write_start_byte(settings[p]);
            calm = (p == 2);
            stream_traffic(120);
        end
        calm = 1'b0;

        drain_frames();
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
